@@ src/dss_pkg.sv @@
// Shared types and codes for the dual stack shared store block.
package dss_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int WORD_W        = 32;

  // operation field, kind[2:1]; kind[0] picks the stack
  localparam logic [1:0] OP_PUSH = 2'd0;
  localparam logic [1:0] OP_POP  = 2'd1;
  localparam logic [1:0] OP_PEEK = 2'd2;
  localparam logic [1:0] OP_DUMP = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;

  typedef struct packed {
    logic       load;     // capture the incoming word
    logic       write;    // push into the store
    logic       pop;      // drop the top of the selected stack
    logic       rd_top;   // start a read at the top of the stack
    logic       rd_next;  // read one entry further down
    logic       out_st;   // load a status-only result
    logic       out_rd;   // load a result from read data
    logic [1:0] st;       // status code for out_st
  } dss_cmd_t;

  typedef struct packed {
    logic is_push;
    logic is_pop;
    logic is_dump;
    logic full;
    logic empty;
    logic walk_last;
  } dss_stat_t;

endpackage

@@ src/dual_stack_shared_store_core.sv @@
// Top level of the dual stack shared store block.
// Two stacks live in one store of DEPTH words: stack one fills upward from
// entry 0, stack two downward from entry DEPTH-1.
// Input channel (in_valid/in_ready): kind selects push, pop, peek or dump on
// either stack; value is the word pushed.
// Output channel (out_valid/out_ready): status, data, last per result word.
// One item is handled at a time; in_ready is high only while idle.
// Push, overflow and empty results are registered in the execute step.
// Pop and peek: the execute step starts a store read and the read step
// loads the result. Dump: the first word is read likewise; each further
// word is read after the previous one is taken, since every word costs one store read.
// A new item can be taken the cycle after the last result word is taken.
// A stalled receiver simply holds the block in its output state.
// Reset empties both stacks; store contents are not cleared.
module dual_stack_shared_store_core #(
  parameter int DEPTH = dss_pkg::DEPTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [2:0]                        kind,
  input  logic signed [dss_pkg::WORD_W-1:0] value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        status,
  output logic signed [dss_pkg::WORD_W-1:0] data,
  output logic                              last
);
  import dss_pkg::*;

  dss_cmd_t  cmd;
  dss_stat_t stat;

  dss_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  dss_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .kind   (kind),
    .value  (value),
    .cmd    (cmd),
    .stat   (stat),
    .status (status),
    .data   (data),
    .last   (last)
  );

`ifndef ASSERT_OFF
  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input and output sides active together");

  a_err_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> last && data == '0)
    else $error("error result must be a single zero word");

  a_no_early: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !out_valid)
    else $error("result shown before execute step");
`endif

endmodule

@@ src/dss_datapath.sv @@
// Datapath: shared store, stack counts, address generation and result register.
module dss_datapath #(
  parameter int DEPTH = dss_pkg::DEPTH_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [2:0]                         kind,
  input  logic signed [dss_pkg::WORD_W-1:0]  value,
  input  dss_pkg::dss_cmd_t                  cmd,
  output dss_pkg::dss_stat_t                 stat,
  output logic [1:0]                         status,
  output logic signed [dss_pkg::WORD_W-1:0]  data,
  output logic                               last
);
  import dss_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rd_data;

  logic [2:0]        kind_q;
  logic [WORD_W-1:0] value_q;
  logic [CW-1:0]     count_one;
  logic [CW-1:0]     count_two;
  logic [AW-1:0]     walk;
  logic [AW-1:0]     walk_next;

  logic              which;
  logic [1:0]        op;
  logic [CW-1:0]     cnt_sel;
  logic [CW:0]       fill;
  logic [CW-1:0]     depth_c;
  logic [CW-1:0]     rd_idx;
  logic [CW-1:0]     wr_idx;

  assign which   = kind_q[0];
  assign op      = kind_q[2:1];
  assign cnt_sel = which ? count_two : count_one;
  assign fill    = {1'b0, count_one} + {1'b0, count_two};
  assign depth_c = CW'(DEPTH);

  assign walk_next = cmd.rd_top ? '0 : walk + AW'(1);

  always_comb begin
    if (which) begin
      rd_idx = depth_c - count_two + CW'(walk_next);
      wr_idx = depth_c - CW'(1) - count_two;
    end else begin
      rd_idx = count_one - CW'(1) - CW'(walk_next);
      wr_idx = count_one;
    end
  end

  assign stat.is_push   = (op == OP_PUSH);
  assign stat.is_pop    = (op == OP_POP);
  assign stat.is_dump   = (op == OP_DUMP);
  assign stat.full      = (fill >= (CW+1)'(DEPTH));
  assign stat.empty     = (cnt_sel == '0);
  assign stat.walk_last = ((CW'(walk) + CW'(1)) == cnt_sel);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_q  <= kind;
      value_q <= value;
    end
    if (cmd.write) begin
      mem[wr_idx[AW-1:0]] <= value_q;
    end
    if (cmd.rd_top || cmd.rd_next) begin
      rd_data <= mem[rd_idx[AW-1:0]];
      walk    <= walk_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count_one <= '0;
      count_two <= '0;
    end else if (cmd.write) begin
      if (which) count_two <= count_two + CW'(1);
      else       count_one <= count_one + CW'(1);
    end else if (cmd.pop) begin
      if (which) count_two <= count_two - CW'(1);
      else       count_one <= count_one - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_st) begin
      status <= cmd.st;
      data   <= '0;
      last   <= 1'b1;
    end else if (cmd.out_rd) begin
      status <= ST_OK;
      data   <= rd_data;
      last   <= !stat.is_dump || stat.walk_last;
    end
  end

endmodule

@@ src/dss_ctrl.sv @@
// Controller: sequences accept, execute, store read and result handoff.
module dss_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  dss_pkg::dss_stat_t stat,
  output dss_pkg::dss_cmd_t  cmd
);
  import dss_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    cmd        = '0;
    cmd.st     = ST_OK;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.is_push) begin
          cmd.out_st = 1'b1;
          if (stat.full) begin
            cmd.st = ST_OVERFLOW;
          end else begin
            cmd.write = 1'b1;
          end
          state_next = S_OUT;
        end else if (stat.empty) begin
          cmd.out_st = 1'b1;
          cmd.st     = ST_EMPTY;
          state_next = S_OUT;
        end else begin
          cmd.rd_top = 1'b1;
          cmd.pop    = stat.is_pop;
          state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.out_rd = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          if (stat.is_dump && !stat.empty && !stat.walk_last) begin
            cmd.rd_next = 1'b1;
            state_next  = S_READ;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

endmodule

@@ sim/dual_stack_shared_store_core_tb.sv @@
// Self-checking testbench for the dual stack shared store core.
module dual_stack_shared_store_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dss_pkg::*;

  localparam int DEPTH        = DEPTH_DEFAULT;
  localparam int RANDOM_ITEMS = 310;
  localparam int STALL_LIMIT  = 3000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 20;
  localparam int IDLE_PCT     = 36;

  localparam logic SIDE_ONE = 1'b0;
  localparam logic SIDE_TWO = 1'b1;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [WORD_W-1:0] data;
    logic                     last;
  } stack_word_t;

  typedef enum {MIX_GROW, MIX_SHRINK, MIX_ANY} mix_t;

  // Tracks both stacks and the result words each request is owed.
  class dual_stack_board_t;
    logic signed [WORD_W-1:0] words [DEPTH];
    int                       cnt_one = 0;
    int                       cnt_two = 0;
    int                       errors  = 0;
    stack_word_t              owed_words [$];

    function int slot_at(logic side, int d);
      if (side == SIDE_ONE) return cnt_one - 1 - d;
      return DEPTH - cnt_two + d;
    endfunction

    function void owe(logic [1:0] st, logic signed [WORD_W-1:0] d, logic l);
      stack_word_t w;
      w.status = st;
      w.data   = d;
      w.last   = l;
      owed_words.push_back(w);
    endfunction

    function void take_request(logic [2:0] k, logic signed [WORD_W-1:0] v);
      logic [1:0] op;
      logic       side;
      int         n;
      int         d;
      op   = k[2:1];
      side = k[0];
      n    = (side == SIDE_TWO) ? cnt_two : cnt_one;
      if (op == OP_PUSH) begin
        if (cnt_one + cnt_two >= DEPTH) begin
          owe(ST_OVERFLOW, '0, 1'b1);
        end else begin
          if (side == SIDE_ONE) begin
            words[cnt_one] = v;
            cnt_one++;
          end else begin
            cnt_two++;
            words[DEPTH - cnt_two] = v;
          end
          owe(ST_OK, '0, 1'b1);
        end
      end else if (n == 0) begin
        owe(ST_EMPTY, '0, 1'b1);
      end else if (op == OP_DUMP) begin
        for (d = 0; d < n; d++) owe(ST_OK, words[slot_at(side, d)], d == n - 1);
      end else begin
        owe(ST_OK, words[slot_at(side, 0)], 1'b1);
        if (op == OP_POP) begin
          if (side == SIDE_TWO) cnt_two--;
          else cnt_one--;
        end
      end
    endfunction

    function void match_word(logic [1:0] st, logic signed [WORD_W-1:0] d, logic l);
      stack_word_t w;
      if (owed_words.size() == 0) begin
        $error("unexpected result word: status %0d data %h last %0b", st, d, l);
        errors++;
        return;
      end
      w = owed_words.pop_front();
      if (st !== w.status) begin
        $error("status: expected %0d, got %0d", w.status, st);
        errors++;
      end
      if (d !== w.data) begin
        $error("data: expected %h, got %h", w.data, d);
        errors++;
      end
      if (l !== w.last) begin
        $error("last: expected %0b, got %0b", w.last, l);
        errors++;
      end
    endfunction
  endclass

  logic                     clk       = 1'b0;
  logic                     rst       = 1'b1;
  logic                     in_valid  = 1'b0;
  logic                     in_ready;
  logic [2:0]               kind      = '0;
  logic signed [WORD_W-1:0] value     = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [1:0]               status;
  logic signed [WORD_W-1:0] data;
  logic                     last;

  dual_stack_shared_store_core #(.DEPTH(DEPTH)) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind      (kind),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .data      (data),
    .last      (last)
  );

  dual_stack_board_t board = new;

  logic calm     = 1'b0;
  logic hold_req = 1'b0;
  int   quiet_cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // handshake monitor and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) board.take_request(kind, value);
      if (out_valid && out_ready) board.match_word(status, data, last);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("dual_stack_shared_store_core_tb: done, errors");
          $finish;
        end
      end
    end
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  task automatic offer(input logic [2:0] k, input logic signed [WORD_W-1:0] v);
    int gap;
    gap = 0;
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind     <= k;
    value    <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic logic [2:0] pick_kind(mix_t mix);
    logic [1:0] op;
    int         r;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_GROW: begin
        if (r < 70) op = OP_PUSH;
        else if (r < 82) op = OP_POP;
        else if (r < 91) op = OP_PEEK;
        else op = OP_DUMP;
      end
      MIX_SHRINK: begin
        if (r < 12) op = OP_PUSH;
        else if (r < 60) op = OP_POP;
        else if (r < 80) op = OP_PEEK;
        else op = OP_DUMP;
      end
      default: op = 2'($urandom_range(0, 3));
    endcase
    return {op, 1'($urandom_range(0, 1))};
  endfunction

  function automatic logic signed [WORD_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh7fff_ffff;
      1:       return 32'sh8000_0000;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic signed [WORD_W-1:0] v;
    mix_t                     mix;
    int                       run_left;
    int                       i;

    mix = MIX_ANY;
    run_left = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // operations on empty stacks
    offer({OP_POP,  SIDE_ONE}, 32'sh1234_5678);
    offer({OP_PEEK, SIDE_TWO}, '0);
    offer({OP_DUMP, SIDE_ONE}, '0);
    offer({OP_DUMP, SIDE_TWO}, '0);

    // fill the store from both ends with extreme words first
    for (i = 0; i < DEPTH; i++) begin
      case (i)
        0:       v = 32'sh7fff_ffff;
        1:       v = 32'sh8000_0000;
        2:       v = '0;
        3:       v = '1;
        default: v = $urandom;
      endcase
      offer({OP_PUSH, (i < DEPTH / 2 + 1) ? SIDE_ONE : SIDE_TWO}, v);
    end

    // stacks meet: overflow on both sides, then full dumps
    offer({OP_PUSH, SIDE_ONE}, 32'sh5555_5555);
    offer({OP_PUSH, SIDE_TWO}, 32'shaaaa_aaaa);
    offer({OP_DUMP, SIDE_ONE}, '0);
    offer({OP_DUMP, SIDE_TWO}, '0);
    offer({OP_PEEK, SIDE_ONE}, '0);
    offer({OP_POP,  SIDE_TWO}, '0);

    // random runs biased to grow or shrink so both full and empty recur
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (run_left == 0) begin
        case ($urandom_range(0, 4))
          0, 1:    mix = MIX_GROW;
          2, 3:    mix = MIX_SHRINK;
          default: mix = MIX_ANY;
        endcase
        run_left = $urandom_range(8, 30);
      end
      run_left--;
      calm = (i >= 100 && i < 170);
      if (i == 220) hold_req = 1'b1;
      offer(pick_kind(mix), pick_value());
    end
    in_valid <= 1'b0;

    // let the monitor log the final request before waiting on its words
    @(posedge clk);
    while (board.owed_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (board.errors == 0 && board.owed_words.size() == 0) begin
      $display("dual_stack_shared_store_core_tb: done, clean");
    end else begin
      $display("dual_stack_shared_store_core_tb: done, errors");
    end
    $finish;
  end

endmodule
